[rtl/rfg_pkg.sv]
package rfg_pkg;

  // Widths fixed by the ports.
  localparam int PIXEL_BITS     = 16;
  localparam int GRAD_BITS      = 17;
  localparam int CFG_BITS       = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int ROW_BITS       = 12;

  // Register reset values and the legal range of the height.
  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_BITS-1:0] HEIGHT_MIN   = 13'd2;
  localparam logic [CFG_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Control flags of a request between the line store and the gradient stage.
  typedef struct packed {
    logic valid;
    logic first_col;
    logic last_col;
    logic frame_last;
  } rfg_ctl_t;

endpackage

[rtl/raster_forward_gradient_edge_unit.sv]
// Channel   Signals                            Direction  Contents
// pixel     pixel_valid / pixel_stall          in         pixel (16 bit grey level)
// result    result_valid / result_stall        out        gradient (17 bit), frame_last
// config    cfg_valid / cfg_ready              in         cfg_index, cfg_data (13 bit)
//
// One pixel per clock unless stalled; each result passes the s1 and output registers.
// The line store has one write and one read port, both used in the accept cycle.
// Reset (synchronous) clears the counters, the held sample and the pipeline valids.
// The line store is not cleared; row zero fills it before any result uses it.
// pixel_stall rises only while a result waits in the output register and
// the gradient stage is also full.
module raster_forward_gradient_edge_unit #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [rfg_pkg::PIXEL_BITS-1:0]      pixel,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [rfg_pkg::GRAD_BITS-1:0]       gradient,
  output logic                                frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rfg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rfg_pkg::CFG_BITS-1:0]        cfg_data
);
  import rfg_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;

  logic [CFG_BITS-1:0]    image_width;
  logic [CFG_BITS-1:0]    image_height;
  logic [LW-1:0]          width_eff;
  logic [CFG_BITS-1:0]    height_eff;

  logic [CW-1:0]          col;
  logic [ROW_BITS-1:0]    row;
  logic [CW-1:0]          col_next;
  logic [ROW_BITS-1:0]    row_next;
  logic                   last_col;
  logic                   last_row;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] px;

  logic [SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] first_above;

  rfg_ctl_t               s1_ctl;
  logic [SAMPLE_BITS-1:0] s1_below;
  logic [SAMPLE_BITS-1:0] s1_here_first;
  logic [SAMPLE_BITS-1:0] s1_right;
  logic                   take;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame size into the supported range.
  always_comb begin
    if (image_width == '0) begin
      width_eff = LW'(1);
    end else if (LW'(image_width) > LW'(MAX_WIDTH)) begin
      width_eff = LW'(MAX_WIDTH);
    end else begin
      width_eff = LW'(image_width);
    end
    if (image_height < HEIGHT_MIN) begin
      height_eff = HEIGHT_MIN;
    end else if (image_height > HEIGHT_LIMIT) begin
      height_eff = HEIGHT_LIMIT;
    end else begin
      height_eff = image_height;
    end
  end

  // Position of the arriving pixel within the frame.
  assign px       = pixel[SAMPLE_BITS-1:0];
  assign last_col = (LW'(col) + LW'(1)) >= width_eff;
  assign last_row = (CFG_BITS'(row) + CFG_BITS'(1)) >= height_eff;
  assign col_next = last_col ? '0 : col + CW'(1);
  assign row_next = last_col ? (last_row ? '0 : row + ROW_BITS'(1)) : row;

  assign pixel_stall = s1_ctl.valid && !take;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Line store: write the new pixel at its column, read the upper-right
  // neighbor one column ahead in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col] <= px;
      s1_right      <= line_mem[col + CW'(1)];
    end
  end

  // Entry zero is also kept in a register, since the first column needs
  // both entry zero and entry one at once. Only rows after the first
  // produce a result.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_below <= px;
      if (col == '0) begin
        first_above   <= px;
        s1_here_first <= first_above;
      end
      s1_ctl.first_col  <= (col == '0);
      s1_ctl.last_col   <= last_col;
      s1_ctl.frame_last <= last_col && last_row;
    end
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else if (accept) begin
      s1_ctl.valid <= (row != '0);
    end else if (take) begin
      s1_ctl.valid <= 1'b0;
    end
  end

  rfg_grad_stage #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_grad (
    .clk          (clk),
    .rst          (rst),
    .ctl          (s1_ctl),
    .below        (s1_below),
    .here_first   (s1_here_first),
    .right        (s1_right),
    .result_stall (result_stall),
    .take         (take),
    .result_valid (result_valid),
    .gradient     (gradient),
    .frame_last   (frame_last)
  );

endmodule

[rtl/rfg_grad_stage.sv]
module rfg_grad_stage #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rfg_pkg::rfg_ctl_t           ctl,
  input  logic [SAMPLE_BITS-1:0]      below,
  input  logic [SAMPLE_BITS-1:0]      here_first,
  input  logic [SAMPLE_BITS-1:0]      right,
  input  logic                        result_stall,
  output logic                        take,
  output logic                        result_valid,
  output logic [rfg_pkg::GRAD_BITS-1:0] gradient,
  output logic                        frame_last
);
  import rfg_pkg::*;

  logic [SAMPLE_BITS-1:0] held_above;
  logic [SAMPLE_BITS-1:0] here;
  logic [SAMPLE_BITS-1:0] diff_v;
  logic [SAMPLE_BITS-1:0] diff_h;
  logic [SAMPLE_BITS:0]   grad_sum;

  // The output register can load whenever it is empty or being drained.
  assign take = !result_valid || !result_stall;

  // The first column takes its upper sample from the copy of entry zero;
  // other columns use the sample read one column earlier.
  assign here = ctl.first_col ? here_first : held_above;

  always_comb begin
    diff_v   = (below >= here) ? (below - here) : (here - below);
    diff_h   = (right >= here) ? (right - here) : (here - right);
    grad_sum = {1'b0, diff_v} + {1'b0, diff_h};
  end

  // Result register and the held upper-right sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      held_above   <= '0;
    end else if (take) begin
      result_valid <= ctl.valid;
      if (ctl.valid) begin
        frame_last <= ctl.frame_last;
        if (ctl.last_col) begin
          gradient <= '0;
        end else begin
          gradient   <= GRAD_BITS'(grad_sum);
          held_above <= right;
        end
      end
    end
  end

endmodule

[rtl/rfg_checker.sv]
module rfg_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                pixel_stall,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic [rfg_pkg::GRAD_BITS-1:0]       gradient,
  input logic                                frame_last
);
  import rfg_pkg::*;

  // A stalled result stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(gradient) && $stable(frame_last))
    else $error("result payload changed while stalled");

  // Input backpressure only comes from a blocked output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall)
    else $error("pixel stalled without output backpressure");

  // The sum of two sample differences cannot exceed twice the full scale.
  a_grad_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> gradient <= GRAD_BITS'(131070))
    else $error("gradient out of range");

endmodule

bind raster_forward_gradient_edge_unit rfg_checker u_rfg_checker (.*);
